### hw/rtl/gss_pkg.sv
// Shared types, constants and microprogram for the golden-section search core.
// Used by gss_seq, gss_dp and golden_section_minimum_search_core; no dependencies.
package gss_pkg;

    // Field and datapath widths
    localparam int POINT_W   = 32;
    localparam int SCORE_W   = 32;
    localparam int ITER_W    = 6;
    localparam int FRAC_W    = 32;
    localparam int PROD_W    = POINT_W + FRAC_W;
    localparam int PHASE_W   = 3;
    localparam int STEP_W    = 5;
    localparam int OP_W      = 4;
    localparam int EMIT_W    = 3;
    localparam int PSEL_W    = 3;
    localparam int COND_W    = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 104;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    // Golden ratios in unsigned Q0.32
    localparam logic [FRAC_W-1:0] INV_PHI  = 32'h9E37_79B9;
    localparam logic [FRAC_W-1:0] INV_PHI2 = 32'h61C8_8647;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ITER = 2'd2;

    // Input and result kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_VALUE = 1'b1;
    localparam logic RES_PROBE  = 1'b0;
    localparam logic RES_FINAL  = 1'b1;

    // Search phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEFT0  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RIGHT0 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEFTN  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RIGHTN = 3'd4;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_ORDER    = 4'd1;
    localparam logic [OP_W-1:0] OP_SPAN     = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_PHI2 = 4'd3;
    localparam logic [OP_W-1:0] OP_SET_LEFT = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_PHI  = 4'd5;
    localparam logic [OP_W-1:0] OP_SET_RGT  = 4'd6;
    localparam logic [OP_W-1:0] OP_LSCORE   = 4'd7;
    localparam logic [OP_W-1:0] OP_RSCORE   = 4'd8;
    localparam logic [OP_W-1:0] OP_DIR      = 4'd9;
    localparam logic [OP_W-1:0] OP_DEC_MUL  = 4'd10;
    localparam logic [OP_W-1:0] OP_NARROW   = 4'd11;
    localparam logic [OP_W-1:0] OP_MUL_DIR  = 4'd12;
    localparam logic [OP_W-1:0] OP_SET_NEW  = 4'd13;
    localparam logic [OP_W-1:0] OP_CLR_ITER = 4'd14;

    // Result emission selects
    localparam logic [EMIT_W-1:0] EM_NONE   = 3'd0;
    localparam logic [EMIT_W-1:0] EM_LEFT   = 3'd1;
    localparam logic [EMIT_W-1:0] EM_RIGHT  = 3'd2;
    localparam logic [EMIT_W-1:0] EM_NEW    = 3'd3;
    localparam logic [EMIT_W-1:0] EM_BOUNDS = 3'd4;
    localparam logic [EMIT_W-1:0] EM_FINAL  = 3'd5;

    // Phase update selects
    localparam logic [PSEL_W-1:0] PS_KEEP   = 3'd0;
    localparam logic [PSEL_W-1:0] PS_IDLE   = 3'd1;
    localparam logic [PSEL_W-1:0] PS_LEFT0  = 3'd2;
    localparam logic [PSEL_W-1:0] PS_RIGHT0 = 3'd3;
    localparam logic [PSEL_W-1:0] PS_DIR    = 3'd4;

    // Jump conditions
    localparam logic [COND_W-1:0] CD_NEVER   = 2'd0;
    localparam logic [COND_W-1:0] CD_ALWAYS  = 2'd1;
    localparam logic [COND_W-1:0] CD_ITER_Z  = 2'd2;
    localparam logic [COND_W-1:0] CD_ITER_LE1 = 2'd3;

    // Microprogram addresses
    localparam logic [STEP_W-1:0] S_ORDER    = 5'd0;
    localparam logic [STEP_W-1:0] S_SPAN     = 5'd1;
    localparam logic [STEP_W-1:0] S_MUL_L    = 5'd2;
    localparam logic [STEP_W-1:0] S_SET_L    = 5'd3;
    localparam logic [STEP_W-1:0] S_MUL_R    = 5'd4;
    localparam logic [STEP_W-1:0] S_SET_R    = 5'd5;
    localparam logic [STEP_W-1:0] S_VAL_L0   = 5'd6;
    localparam logic [STEP_W-1:0] S_VAL_R    = 5'd7;
    localparam logic [STEP_W-1:0] S_VAL_LN   = 5'd8;
    localparam logic [STEP_W-1:0] S_ADV      = 5'd9;
    localparam logic [STEP_W-1:0] S_ADV_MUL  = 5'd10;
    localparam logic [STEP_W-1:0] S_NARROW   = 5'd11;
    localparam logic [STEP_W-1:0] S_MUL_NEW  = 5'd12;
    localparam logic [STEP_W-1:0] S_SET_NEW  = 5'd13;
    localparam logic [STEP_W-1:0] S_EMIT_NEW = 5'd14;
    localparam logic [STEP_W-1:0] S_FIN      = 5'd15;
    localparam logic [STEP_W-1:0] S_BOUNDS   = 5'd16;
    localparam logic [STEP_W-1:0] S_IGNORE   = 5'd17;

    // Control to the datapath for one executed step
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [EMIT_W-1:0] emit;
        logic [PSEL_W-1:0] phase_sel;
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic               iter_zero;
        logic               iter_le1;
        logic [PHASE_W-1:0] phase;
    } status_t;

    // One microcode word
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [EMIT_W-1:0] emit;
        logic [PSEL_W-1:0] phase_sel;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ucode_t;

    function automatic ucode_t mk(input logic [OP_W-1:0] op, input logic [EMIT_W-1:0] emit,
                                  input logic [PSEL_W-1:0] psel, input logic [COND_W-1:0] cond,
                                  input logic [STEP_W-1:0] target, input logic last);
        ucode_t w;
        w.op        = op;
        w.emit      = emit;
        w.phase_sel = psel;
        w.cond      = cond;
        w.target    = target;
        w.last      = last;
        return w;
    endfunction

    // Control store
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            // start: order bounds, then two interior points
            S_ORDER:    w = mk(OP_ORDER,    EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            S_SPAN:     w = mk(OP_SPAN,     EM_NONE,   PS_KEEP,   CD_ITER_Z,   S_BOUNDS, 1'b0);
            S_MUL_L:    w = mk(OP_MUL_PHI2, EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            S_SET_L:    w = mk(OP_SET_LEFT, EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            S_MUL_R:    w = mk(OP_MUL_PHI,  EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            S_SET_R:    w = mk(OP_SET_RGT,  EM_LEFT,   PS_LEFT0,  CD_NEVER,    S_ORDER,  1'b1);
            // objective values
            S_VAL_L0:   w = mk(OP_LSCORE,   EM_RIGHT,  PS_RIGHT0, CD_NEVER,    S_ORDER,  1'b1);
            S_VAL_R:    w = mk(OP_RSCORE,   EM_NONE,   PS_KEEP,   CD_ALWAYS,   S_ADV,    1'b0);
            S_VAL_LN:   w = mk(OP_LSCORE,   EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            // narrow the bracket or finish
            S_ADV:      w = mk(OP_DIR,      EM_NONE,   PS_KEEP,   CD_ITER_LE1, S_FIN,    1'b0);
            S_ADV_MUL:  w = mk(OP_DEC_MUL,  EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            S_NARROW:   w = mk(OP_NARROW,   EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            S_MUL_NEW:  w = mk(OP_MUL_DIR,  EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            S_SET_NEW:  w = mk(OP_SET_NEW,  EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b0);
            S_EMIT_NEW: w = mk(OP_NONE,     EM_NEW,    PS_DIR,    CD_NEVER,    S_ORDER,  1'b1);
            S_FIN:      w = mk(OP_CLR_ITER, EM_FINAL,  PS_IDLE,   CD_NEVER,    S_ORDER,  1'b1);
            S_BOUNDS:   w = mk(OP_NONE,     EM_BOUNDS, PS_IDLE,   CD_NEVER,    S_ORDER,  1'b1);
            S_IGNORE:   w = mk(OP_NONE,     EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b1);
            default:    w = mk(OP_NONE,     EM_NONE,   PS_KEEP,   CD_NEVER,    S_ORDER,  1'b1);
        endcase
        return w;
    endfunction

    // Entry address for an accepted word
    function automatic logic [STEP_W-1:0] entry_step(input logic kind,
                                                     input logic [PHASE_W-1:0] phase);
        logic [STEP_W-1:0] s;
        if (kind == KIND_START) begin
            s = S_ORDER;
        end else begin
            unique case (phase) inside
                PH_LEFT0:             s = S_VAL_L0;
                PH_RIGHT0, PH_RIGHTN: s = S_VAL_R;
                PH_LEFTN:             s = S_VAL_LN;
                default:              s = S_IGNORE;
            endcase
        end
        return s;
    endfunction

endpackage

### hw/rtl/gss_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on gss_pkg.
module gss_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_kind,
    input  logic              out_blocked,
    input  gss_pkg::status_t  status,
    output gss_pkg::ctrl_t    ctrl,
    output logic              busy
);
    import gss_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            uw;
    logic              stall;
    logic              fire;
    logic              take_jump;

    // Fetch and hold on a full result register
    assign uw    = ucode_rom(step_reg);
    assign stall = (uw.emit != EM_NONE) && out_blocked;
    assign fire  = busy_reg && !stall;
    assign busy  = busy_reg;

    // Evaluate jump condition
    always_comb
    begin
        case (uw.cond)
            CD_NEVER:    take_jump = 1'b0;
            CD_ALWAYS:   take_jump = 1'b1;
            CD_ITER_Z:   take_jump = status.iter_zero;
            CD_ITER_LE1: take_jump = status.iter_le1;
            default:     take_jump = 1'b0;
        endcase
    end

    // Advance the step counter
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (in_fire)
        begin
            busy_next = 1'b1;
            step_next = entry_step(in_kind, status.phase);
        end
        else if (fire)
        begin
            if (uw.last)
            begin
                busy_next = 1'b0;
            end
            else if (take_jump)
            begin
                step_next = uw.target;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= S_ORDER;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Drive the datapath only on executed steps
    always_comb
    begin
        ctrl.op        = fire ? uw.op        : OP_NONE;
        ctrl.emit      = fire ? uw.emit      : EM_NONE;
        ctrl.phase_sel = fire ? uw.phase_sel : PS_KEEP;
    end

endmodule

### hw/rtl/gss_dp.sv
// Search datapath: bracket and point registers, one 32x32 multiplier, result register.
// Depends on gss_pkg; driven by gss_seq.
module gss_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [gss_pkg::POINT_W-1:0] cfg_low,
    input  logic signed [gss_pkg::POINT_W-1:0] cfg_high,
    input  logic        [gss_pkg::ITER_W-1:0]  cfg_iter,
    input  logic                               in_fire,
    input  logic signed [gss_pkg::SCORE_W-1:0] in_value,
    input  gss_pkg::ctrl_t                     ctrl,
    output gss_pkg::status_t                   status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               res_kind,
    output logic signed [gss_pkg::POINT_W-1:0] probe_point,
    output logic                               final_probe,
    output logic signed [gss_pkg::POINT_W-1:0] interval_low,
    output logic signed [gss_pkg::POINT_W-1:0] interval_high
);
    import gss_pkg::*;

    // Control state
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               ovalid_reg, ovalid_next;

    // Payload
    logic signed [POINT_W-1:0] blo_reg, blo_next;
    logic signed [POINT_W-1:0] bhi_reg, bhi_next;
    logic        [POINT_W-1:0] span_reg, span_next;
    logic signed [POINT_W-1:0] left_reg, left_next;
    logic signed [POINT_W-1:0] right_reg, right_next;
    logic signed [SCORE_W-1:0] lscore_reg, lscore_next;
    logic signed [SCORE_W-1:0] rscore_reg, rscore_next;
    logic signed [SCORE_W-1:0] value_reg, value_next;
    logic        [PROD_W-1:0]  prod_reg, prod_next;
    logic                      dir_reg, dir_next;
    logic                      rkind_reg, rkind_next;
    logic signed [POINT_W-1:0] probe_reg, probe_next;
    logic                      last_reg, last_next;
    logic signed [POINT_W-1:0] ilo_reg, ilo_next;
    logic signed [POINT_W-1:0] ihi_reg, ihi_next;

    logic        [FRAC_W-1:0]  coef;
    logic        [PROD_W-1:0]  mul_out;
    logic        [PROD_W-1:0]  prod_rnd;
    logic        [POINT_W-1:0] rounded;
    logic signed [POINT_W-1:0] new_pt;
    logic                      go_left;

    // Multiplier coefficient select
    always_comb
    begin
        case (ctrl.op)
            OP_MUL_PHI2: coef = INV_PHI2;
            OP_MUL_DIR:  coef = dir_reg ? INV_PHI2 : INV_PHI;
            default:     coef = INV_PHI;
        endcase
    end

    assign mul_out  = PROD_W'(span_reg) * PROD_W'(coef);
    assign prod_rnd = prod_reg + ROUND_HALF;
    assign rounded  = prod_rnd[PROD_W-1 -: POINT_W];
    assign new_pt   = blo_reg + $signed(rounded);
    assign go_left  = lscore_reg < rscore_reg;

    assign status.iter_zero = (iter_reg == '0);
    assign status.iter_le1  = (iter_reg <= ITER_W'(1));
    assign status.phase     = phase_reg;

    // Execute one datapath operation
    always_comb
    begin
        iter_next   = iter_reg;
        blo_next    = blo_reg;
        bhi_next    = bhi_reg;
        span_next   = span_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        lscore_next = lscore_reg;
        rscore_next = rscore_reg;
        prod_next   = prod_reg;
        dir_next    = dir_reg;
        value_next  = in_fire ? in_value : value_reg;
        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_ORDER:
            begin
                if (cfg_high < cfg_low)
                begin
                    blo_next = cfg_high;
                    bhi_next = cfg_low;
                end
                else
                begin
                    blo_next = cfg_low;
                    bhi_next = cfg_high;
                end
                iter_next = cfg_iter;
            end
            OP_SPAN:     span_next = POINT_W'(bhi_reg - blo_reg);
            OP_MUL_PHI2,
            OP_MUL_PHI,
            OP_MUL_DIR:  prod_next = mul_out;
            OP_SET_LEFT: left_next = new_pt;
            OP_SET_RGT:  right_next = new_pt;
            OP_LSCORE:   lscore_next = value_reg;
            OP_RSCORE:   rscore_next = value_reg;
            OP_DIR:      dir_next = go_left;
            OP_DEC_MUL:
            begin
                iter_next = iter_reg - ITER_W'(1);
                prod_next = mul_out;
            end
            OP_NARROW:
            begin
                span_next = rounded;
                if (dir_reg)
                begin
                    bhi_next    = right_reg;
                    right_next  = left_reg;
                    rscore_next = lscore_reg;
                end
                else
                begin
                    blo_next    = left_reg;
                    left_next   = right_reg;
                    lscore_next = rscore_reg;
                end
            end
            OP_SET_NEW:
            begin
                if (dir_reg)
                begin
                    left_next = new_pt;
                end
                else
                begin
                    right_next = new_pt;
                end
            end
            OP_CLR_ITER: iter_next = '0;
            default:
            begin
            end
        endcase
    end

    // Update the search phase
    always_comb
    begin
        unique case (ctrl.phase_sel)
            PS_KEEP:   phase_next = phase_reg;
            PS_IDLE:   phase_next = PH_IDLE;
            PS_LEFT0:  phase_next = PH_LEFT0;
            PS_RIGHT0: phase_next = PH_RIGHT0;
            PS_DIR:    phase_next = dir_reg ? PH_LEFTN : PH_RIGHTN;
            default:   phase_next = phase_reg;
        endcase
    end

    // Load the result register, drop it once taken
    always_comb
    begin
        rkind_next  = rkind_reg;
        probe_next  = probe_reg;
        last_next   = last_reg;
        ilo_next    = ilo_reg;
        ihi_next    = ihi_reg;
        ovalid_next = ovalid_reg && !out_ready;
        if (ctrl.emit != EM_NONE)
        begin
            ovalid_next = 1'b1;
            rkind_next  = RES_PROBE;
            probe_next  = '0;
            last_next   = (iter_reg == ITER_W'(1));
            ilo_next    = '0;
            ihi_next    = '0;
            unique case (ctrl.emit)
                EM_LEFT:  probe_next = left_reg;
                EM_RIGHT: probe_next = right_reg;
                EM_NEW:   probe_next = dir_reg ? left_reg : right_reg;
                EM_BOUNDS:
                begin
                    rkind_next = RES_FINAL;
                    last_next  = 1'b0;
                    ilo_next   = blo_reg;
                    ihi_next   = bhi_reg;
                end
                EM_FINAL:
                begin
                    rkind_next = RES_FINAL;
                    last_next  = 1'b0;
                    ilo_next   = dir_reg ? blo_reg : left_reg;
                    ihi_next   = dir_reg ? right_reg : bhi_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg   <= '0;
            phase_reg  <= PH_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            iter_reg   <= iter_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blo_reg    <= blo_next;
        bhi_reg    <= bhi_next;
        span_reg   <= span_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        lscore_reg <= lscore_next;
        rscore_reg <= rscore_next;
        value_reg  <= value_next;
        prod_reg   <= prod_next;
        dir_reg    <= dir_next;
        rkind_reg  <= rkind_next;
        probe_reg  <= probe_next;
        last_reg   <= last_next;
        ilo_reg    <= ilo_next;
        ihi_reg    <= ihi_next;
    end

    assign out_valid     = ovalid_reg;
    assign res_kind      = rkind_reg;
    assign probe_point   = probe_reg;
    assign final_probe   = last_reg;
    assign interval_low  = ilo_reg;
    assign interval_high = ihi_reg;

endmodule

### hw/rtl/golden_section_minimum_search_core.sv
// Golden-section minimum search core. A start word orders the bounds and leads to the first
// probe (to the bounds when the count is zero); an objective value leads to the second probe,
// the final interval or a new probe. The microprogram walks its steps through one shared
// multiplier; an emitting step holds while a result waits untaken. One word in work at a time;
// the next is taken after the last step.
// Reset (rst_n, asynchronous, active low) clears config registers, phase, count, result valid.
module golden_section_minimum_search_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gss_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gss_pkg::IN_DATA_W-1:0]    s_tdata,  // [31:0] objective_value
    input  logic                             s_tuser,  // [0] kind
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gss_pkg::OUT_DATA_W-1:0]   m_tdata,  // [31:0] probe_point, [32] final_probe,
                                                       // [64:33] interval_low,
                                                       // [96:65] interval_high, [103:97] zero
    output logic                             m_tuser   // [0] result_kind
);
    import gss_pkg::*;

    logic signed [POINT_W-1:0] low_reg;
    logic signed [POINT_W-1:0] high_reg;
    logic        [ITER_W-1:0]  iter_cfg_reg;
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      reg_idx;

    logic                      in_fire;
    logic                      busy;
    ctrl_t                     ctrl;
    status_t                   status;
    logic                      out_valid;
    logic                      res_kind;
    logic signed [POINT_W-1:0] probe_point;
    logic                      final_probe;
    logic signed [POINT_W-1:0] interval_low;
    logic signed [POINT_W-1:0] interval_high;

    // Register writes
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg      <= '0;
            high_reg     <= '0;
            iter_cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_LOW:  low_reg      <= pwdata[POINT_W-1:0];
                REG_HIGH: high_reg     <= pwdata[POINT_W-1:0];
                REG_ITER: iter_cfg_reg <= pwdata[ITER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_LOW:  prdata = low_reg;
            REG_HIGH: prdata = high_reg;
            REG_ITER: prdata = {{(32 - ITER_W){1'b0}}, iter_cfg_reg};
            default:  prdata = '0;
        endcase
    end

    // Input handshake
    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;

    gss_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_kind     (s_tuser),
        .out_blocked (out_valid && !m_tready),
        .status      (status),
        .ctrl        (ctrl),
        .busy        (busy)
    );

    gss_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_low       (low_reg),
        .cfg_high      (high_reg),
        .cfg_iter      (iter_cfg_reg),
        .in_fire       (in_fire),
        .in_value      (s_tdata[SCORE_W-1:0]),
        .ctrl          (ctrl),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (m_tready),
        .res_kind      (res_kind),
        .probe_point   (probe_point),
        .final_probe   (final_probe),
        .interval_low  (interval_low),
        .interval_high (interval_high)
    );

    // Pack the result word
    assign m_tvalid = out_valid;
    assign m_tuser  = res_kind;
    assign m_tdata  = {{(OUT_DATA_W - 3 * POINT_W - 1){1'b0}},
                       interval_high, interval_low, final_probe, probe_point};

endmodule
